FILE: sv/s20_pkg.sv
package s20_pkg;

    localparam logic [31:0] SIGMA0   = 32'h61707865;
    localparam logic [31:0] SIGMA3   = 32'h6b206574;
    localparam logic [31:0] S1_LONG  = 32'h3320646e;
    localparam logic [31:0] S2_LONG  = 32'h79622d32;
    localparam logic [31:0] S1_SHORT = 32'h3120646e;
    localparam logic [31:0] S2_SHORT = 32'h79622d36;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LO_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LO_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HI_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HI_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_KEY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE    = 3'd5;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] matrix_t;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       final_out;
    } out_item_t;

    // core status toward the byte path
    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WRITE
    } core_state_t;

    function automatic word_t rotl(input word_t v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    // one quarter round on (a,b,c,d)
    function automatic logic [127:0] qr(input word_t a, input word_t b,
                                        input word_t c, input word_t d);
        word_t b2;
        word_t c2;
        word_t d2;
        word_t a2;
        b2 = b ^ rotl(a + d, 7);
        c2 = c ^ rotl(b2 + a, 9);
        d2 = d ^ rotl(c2 + b2, 13);
        a2 = a ^ rotl(d2 + c2, 18);
        qr = {a2, b2, c2, d2};
    endfunction

endpackage

FILE: sv/s20_stream_if.sv
interface s20_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/s20_ram.sv
module s20_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/s20_core.sv
// Round-iterative Salsa20 core: one half round (column or row) per cycle,
// then a write state stores the 16 finished words in the keystream RAM, 4 bytes
// per word over a 32-bit-wide memory.
module s20_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  s20_pkg::matrix_t  init,
    output s20_pkg::core_stat_t stat,
    output logic              we,
    output logic [3:0]        waddr,
    output s20_pkg::word_t    wdata
);
    localparam int HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int RW = $clog2(HALF_ROUNDS + 1);

    s20_pkg::core_state_t state_reg, state_next;
    s20_pkg::matrix_t in_reg, w_reg, w_next, half;
    logic [RW-1:0] rnd_reg, rnd_next;
    logic [3:0]    idx_reg, idx_next;

    always_comb
    begin
        half = w_reg;
        if (!rnd_reg[0])
        begin
            {half[0],  half[4],  half[8],  half[12]} = s20_pkg::qr(w_reg[0],  w_reg[4],  w_reg[8],  w_reg[12]);
            {half[5],  half[9],  half[13], half[1]}  = s20_pkg::qr(w_reg[5],  w_reg[9],  w_reg[13], w_reg[1]);
            {half[10], half[14], half[2],  half[6]}  = s20_pkg::qr(w_reg[10], w_reg[14], w_reg[2],  w_reg[6]);
            {half[15], half[3],  half[7],  half[11]} = s20_pkg::qr(w_reg[15], w_reg[3],  w_reg[7],  w_reg[11]);
        end
        else
        begin
            {half[0],  half[1],  half[2],  half[3]}  = s20_pkg::qr(w_reg[0],  w_reg[1],  w_reg[2],  w_reg[3]);
            {half[5],  half[6],  half[7],  half[4]}  = s20_pkg::qr(w_reg[5],  w_reg[6],  w_reg[7],  w_reg[4]);
            {half[10], half[11], half[8],  half[9]}  = s20_pkg::qr(w_reg[10], w_reg[11], w_reg[8],  w_reg[9]);
            {half[15], half[12], half[13], half[14]} = s20_pkg::qr(w_reg[15], w_reg[12], w_reg[13], w_reg[14]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            s20_pkg::ST_IDLE:
                if (start) state_next = s20_pkg::ST_RUN;
            s20_pkg::ST_RUN:
                if (rnd_reg == RW'(HALF_ROUNDS - 1)) state_next = s20_pkg::ST_WRITE;
            s20_pkg::ST_WRITE:
                if (idx_reg == 4'd15) state_next = s20_pkg::ST_IDLE;
            default: state_next = s20_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        rnd_next = rnd_reg;
        idx_next = idx_reg;
        w_next   = w_reg;
        unique case (state_reg)
            s20_pkg::ST_IDLE:
            begin
                rnd_next = '0;
                idx_next = '0;
                if (start) w_next = init;
            end
            s20_pkg::ST_RUN:
            begin
                w_next   = half;
                rnd_next = rnd_reg + RW'(1);
            end
            s20_pkg::ST_WRITE:
                idx_next = idx_reg + 4'd1;
            default: ;
        endcase
    end

    always_comb
    begin
        we    = (state_reg == s20_pkg::ST_WRITE);
        waddr = idx_reg;
        wdata = w_reg[idx_reg] + in_reg[idx_reg];
        stat.busy = (state_reg != s20_pkg::ST_IDLE);
        stat.done = (state_reg == s20_pkg::ST_WRITE) && (idx_reg == 4'd15);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= s20_pkg::ST_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        if (state_reg == s20_pkg::ST_IDLE && start)
        begin
            in_reg <= init;
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == s20_pkg::ST_IDLE)
        else $error("core started while busy");
    a_write_order: assert property (@(posedge clk) disable iff (!rst_n)
        (we && idx_reg != 4'd15) |=> we && idx_reg == $past(idx_reg) + 4'd1)
        else $error("keystream write sequence broken");
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == s20_pkg::ST_RUN && rnd_reg == '0) |-> $past(start))
        else $error("round count not from start");
endmodule

FILE: sv/salsa20_stream_cipher.sv
// Channel  | Dir | Payload                       | Transfer
// ---------+-----+-------------------------------+------------------------
// in_ch    | in  | message_byte[7:0], final_byte | valid && ready
// out_ch   | out | cipher_byte[7:0], final_out   | valid && ready
// cfg      | in  | cfg_index[2:0], cfg_data[63:0]| cfg_we
//
// One byte per cycle within a block while the output queue has room. A byte
// at position 0 first needs a new keystream block: the last byte leaves
// lookup, the core is launched, runs its half rounds and writes the 32-bit
// words into the keystream RAM, and only then is byte 0 taken; bytes 1..63
// then flow one per cycle while the output queue has room. A register write
// while a block waits in the RAM (or is being made) forces the block to be
// made again with the new values.
// The keystream RAM read is registered; a byte is held in a lookup stage and
// then a four-entry output queue so the input stays open while a result
// waits. Reset clears position, counter and handshake state, zeroes the key
// and nonce registers and selects the long key; the RAM holds no reset value
// and is always written before it is read.
module salsa20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic clk,
    input  logic rst_n,
    s20_stream_if.sink   in_ch,
    s20_stream_if.source out_ch,
    input  logic                            cfg_we,
    input  logic [s20_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [s20_pkg::CFG_DATA_W-1:0]  cfg_data
);
    // configuration registers
    logic [63:0] key_lo_a_reg, key_lo_b_reg, key_hi_a_reg, key_hi_b_reg, nonce_reg;
    logic        long_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_a_reg <= '0;
            key_lo_b_reg <= '0;
            key_hi_a_reg <= '0;
            key_hi_b_reg <= '0;
            long_key_reg <= 1'b1;
            nonce_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                s20_pkg::REG_KEY_LO_A: key_lo_a_reg <= cfg_data;
                s20_pkg::REG_KEY_LO_B: key_lo_b_reg <= cfg_data;
                s20_pkg::REG_KEY_HI_A: key_hi_a_reg <= cfg_data;
                s20_pkg::REG_KEY_HI_B: key_hi_b_reg <= cfg_data;
                s20_pkg::REG_LONG_KEY: long_key_reg <= cfg_data[0];
                s20_pkg::REG_NONCE:    nonce_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // block input matrix
    s20_pkg::matrix_t init;
    logic [63:0] k2a, k2b, cnt_reg, cnt_next;
    logic [5:0]  pos_reg, pos_next;

    always_comb
    begin
        k2a = long_key_reg ? key_hi_a_reg : key_lo_a_reg;
        k2b = long_key_reg ? key_hi_b_reg : key_lo_b_reg;
        init[0]  = s20_pkg::SIGMA0;
        init[1]  = key_lo_a_reg[31:0];
        init[2]  = key_lo_a_reg[63:32];
        init[3]  = key_lo_b_reg[31:0];
        init[4]  = key_lo_b_reg[63:32];
        init[5]  = long_key_reg ? s20_pkg::S1_LONG : s20_pkg::S1_SHORT;
        init[6]  = nonce_reg[31:0];
        init[7]  = nonce_reg[63:32];
        init[8]  = cnt_reg[31:0];
        init[9]  = cnt_reg[63:32];
        init[10] = long_key_reg ? s20_pkg::S2_LONG : s20_pkg::S2_SHORT;
        init[11] = k2a[31:0];
        init[12] = k2a[63:32];
        init[13] = k2b[31:0];
        init[14] = k2b[63:32];
        init[15] = s20_pkg::SIGMA3;
    end

    // block generation
    s20_pkg::core_stat_t stat;
    logic           ks_we;
    logic [3:0]     ks_waddr;
    s20_pkg::word_t ks_wdata, ks_rdata;
    logic           fresh_reg, fresh_next;   // block for pos 0 is in RAM
    logic           dirty_reg, dirty_next;   // registers changed since launch
    logic           start;

    s20_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .init  (init),
        .stat  (stat),
        .we    (ks_we),
        .waddr (ks_waddr),
        .wdata (ks_wdata)
    );

    // lookup stage and four-entry output queue
    logic       look_vld_reg;
    logic [7:0] look_msg_reg;
    logic       look_fin_reg;
    logic [1:0] look_sel_reg;
    s20_pkg::out_item_t q_reg [4];
    logic [2:0] q_cnt_reg, q_cnt_next;
    logic [1:0] q_wptr_reg, q_rptr_reg;
    logic       accept, pop;
    logic [7:0] ks_byte;

    // keep space for the item in lookup plus the new one
    assign in_ch.ready = (fresh_reg || pos_reg != 6'd0) && !stat.busy
                         && (q_cnt_reg + {2'b0, look_vld_reg}) < 3'd4;
    assign accept = in_ch.valid && in_ch.ready;
    assign start  = !fresh_reg && pos_reg == 6'd0 && !stat.busy && !look_vld_reg;
    assign pop    = out_ch.valid && out_ch.ready;

    s20_ram #(.WIDTH(32), .DEPTH(16)) u_ks_ram (
        .clk   (clk),
        .we    (ks_we),
        .waddr (ks_waddr),
        .wdata (ks_wdata),
        .raddr (pos_reg[5:2]),
        .rdata (ks_rdata)
    );

    always_comb
    begin
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        fresh_next = fresh_reg;
        dirty_next = (dirty_reg && !start) || cfg_we;
        if (stat.done)
        begin
            // a block made from stale registers is discarded
            fresh_next = !dirty_reg && !cfg_we;
        end
        if (cfg_we)
        begin
            fresh_next = 1'b0;
        end
        if (accept)
        begin
            fresh_next = 1'b0;
            if (in_ch.data.final_byte)
            begin
                pos_next = '0;
                cnt_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 6'd1;
                if (pos_reg == 6'd63) cnt_next = cnt_reg + 64'd1;
            end
        end
    end

    always_comb
    begin
        unique case (look_sel_reg)
            2'd0: ks_byte = ks_rdata[7:0];
            2'd1: ks_byte = ks_rdata[15:8];
            2'd2: ks_byte = ks_rdata[23:16];
            2'd3: ks_byte = ks_rdata[31:24];
            default: ks_byte = ks_rdata[7:0];
        endcase
    end

    always_comb
    begin
        q_cnt_next = q_cnt_reg + {2'b0, look_vld_reg} - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            cnt_reg      <= '0;
            fresh_reg    <= 1'b0;
            dirty_reg    <= 1'b0;
            look_vld_reg <= 1'b0;
            q_cnt_reg    <= '0;
            q_wptr_reg   <= '0;
            q_rptr_reg   <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            cnt_reg      <= cnt_next;
            fresh_reg    <= fresh_next;
            dirty_reg    <= dirty_next;
            look_vld_reg <= accept;
            q_cnt_reg    <= q_cnt_next;
            if (look_vld_reg) q_wptr_reg <= q_wptr_reg + 2'd1;
            if (pop)          q_rptr_reg <= q_rptr_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            look_msg_reg <= in_ch.data.message_byte;
            look_fin_reg <= in_ch.data.final_byte;
            look_sel_reg <= pos_reg[1:0];
        end
        if (look_vld_reg)
        begin
            q_reg[q_wptr_reg] <= '{cipher_byte: look_msg_reg ^ ks_byte,
                                   final_out: look_fin_reg};
        end
    end

    assign out_ch.valid = (q_cnt_reg != 3'd0);
    assign out_ch.data  = q_reg[q_rptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_cnt_reg == 3'd4 && look_vld_reg && !pop))
        else $error("output queue overflow");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !stat.busy && !ks_we)
        else $error("byte taken during block generation");
    a_block_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pos_reg == 6'd0) |-> fresh_reg)
        else $error("byte 0 taken before block made");
    a_wrap_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pos_reg == 6'd63 && !in_ch.data.final_byte)
        |=> cnt_reg == $past(cnt_reg) + 64'd1)
        else $error("block counter not advanced");
endmodule

FILE: tb/salsa20_keystream_checker.sv
`timescale 1ns / 100ps

module salsa20_keystream_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  s20_pkg::in_item_t              in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  s20_pkg::out_item_t             out_data,
    input  logic                           cfg_we,
    input  logic [s20_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [s20_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             pending
);

    localparam int DOUBLE_ROUNDS = 10;

    logic [63:0] key_lo_a;
    logic [63:0] key_lo_b;
    logic [63:0] key_hi_a;
    logic [63:0] key_hi_b;
    logic        long_key;
    logic [63:0] nonce_value;

    logic [7:0]     pad_bytes [64];
    logic [5:0]     byte_pos;
    logic [63:0]    block_num;
    s20_pkg::word_t mix [16];

    s20_pkg::out_item_t expected_bytes [$];

    assign pending = expected_bytes.size();

    function automatic s20_pkg::word_t rot_left(input s20_pkg::word_t v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void quarter(input int a, input int b, input int c, input int d);
        mix[b] = mix[b] ^ rot_left(mix[a] + mix[d], 7);
        mix[c] = mix[c] ^ rot_left(mix[b] + mix[a], 9);
        mix[d] = mix[d] ^ rot_left(mix[c] + mix[b], 13);
        mix[a] = mix[a] ^ rot_left(mix[d] + mix[c], 18);
    endfunction

    function automatic void build_pad();
        s20_pkg::word_t start [16];
        logic [63:0]    k2a;
        logic [63:0]    k2b;
        s20_pkg::word_t v;
        k2a = long_key ? key_hi_a : key_lo_a;
        k2b = long_key ? key_hi_b : key_lo_b;
        start[0]  = s20_pkg::SIGMA0;
        start[1]  = key_lo_a[31:0];
        start[2]  = key_lo_a[63:32];
        start[3]  = key_lo_b[31:0];
        start[4]  = key_lo_b[63:32];
        start[5]  = long_key ? s20_pkg::S1_LONG : s20_pkg::S1_SHORT;
        start[6]  = nonce_value[31:0];
        start[7]  = nonce_value[63:32];
        start[8]  = block_num[31:0];
        start[9]  = block_num[63:32];
        start[10] = long_key ? s20_pkg::S2_LONG : s20_pkg::S2_SHORT;
        start[11] = k2a[31:0];
        start[12] = k2a[63:32];
        start[13] = k2b[31:0];
        start[14] = k2b[63:32];
        start[15] = s20_pkg::SIGMA3;
        for (int i = 0; i < 16; i++)
            mix[i] = start[i];
        for (int r = 0; r < DOUBLE_ROUNDS; r++)
        begin
            quarter(0, 4, 8, 12);
            quarter(5, 9, 13, 1);
            quarter(10, 14, 2, 6);
            quarter(15, 3, 7, 11);
            quarter(0, 1, 2, 3);
            quarter(5, 6, 7, 4);
            quarter(10, 11, 8, 9);
            quarter(15, 12, 13, 14);
        end
        for (int i = 0; i < 16; i++)
        begin
            v = mix[i] + start[i];
            for (int j = 0; j < 4; j++)
                pad_bytes[4 * i + j] = v[8 * j +: 8];
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int errs;
        s20_pkg::out_item_t e;
        errs = 0;
        if (!rst_n)
        begin
            key_lo_a    = '0;
            key_lo_b    = '0;
            key_hi_a    = '0;
            key_hi_b    = '0;
            long_key    = 1'b1;
            nonce_value = '0;
            byte_pos    = '0;
            block_num   = '0;
            mismatches  <= 0;
            expected_bytes.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    s20_pkg::REG_KEY_LO_A: key_lo_a    = cfg_data;
                    s20_pkg::REG_KEY_LO_B: key_lo_b    = cfg_data;
                    s20_pkg::REG_KEY_HI_A: key_hi_a    = cfg_data;
                    s20_pkg::REG_KEY_HI_B: key_hi_b    = cfg_data;
                    s20_pkg::REG_LONG_KEY: long_key    = cfg_data[0];
                    s20_pkg::REG_NONCE:    nonce_value = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (byte_pos == 0)
                    build_pad();
                e.cipher_byte = in_data.message_byte ^ pad_bytes[byte_pos];
                e.final_out   = in_data.final_byte;
                expected_bytes.insert(expected_bytes.size(), e);
                if (in_data.final_byte)
                begin
                    byte_pos  = '0;
                    block_num = '0;
                end
                else
                begin
                    byte_pos = byte_pos + 6'd1;
                    if (byte_pos == 0)
                        block_num = block_num + 64'd1;
                end
            end
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h/%b",
                             $time, out_data.cipher_byte, out_data.final_out);
                    errs++;
                end
                else
                begin
                    e = expected_bytes.pop_front();
                    if (e.cipher_byte !== out_data.cipher_byte)
                    begin
                        $display("%0t: cipher_byte expected %h, actual %h",
                                 $time, e.cipher_byte, out_data.cipher_byte);
                        errs++;
                    end
                    if (e.final_out !== out_data.final_out)
                    begin
                        $display("%0t: final_out expected %b, actual %b",
                                 $time, e.final_out, out_data.final_out);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                mismatches <= mismatches + errs;
        end
    end

endmodule

FILE: tb/salsa20_stream_cipher_tb.sv
`timescale 1ns / 100ps

module salsa20_stream_cipher_tb;

    // an index past the last register; writes to it must be dropped
    localparam logic [s20_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           cfg_we;
    logic [s20_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [s20_pkg::CFG_DATA_W-1:0] cfg_data;

    s20_stream_if #(.T(s20_pkg::in_item_t))  in_ch ();
    s20_stream_if #(.T(s20_pkg::out_item_t)) out_ch ();

    int mismatches;
    int pending;
    int cycles = 0;

    // flow-control knobs shared by the sender and the receiver
    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;

    salsa20_stream_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    salsa20_keystream_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_data    (in_ch.data),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_data   (out_ch.data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: random back-pressure bursts, plus one long hold-off on request
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // one byte transfer; valid stays up between back-to-back bytes
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (gaps_on && $urandom_range(0, 6) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.data.message_byte <= b;
        in_ch.data.final_byte   <= fin;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // let the block drain, then sit idle long enough for any core work to finish
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // back-to-back register writes, write enable dropped once at the end
    task automatic load_regs(input logic [63:0] ka, input logic [63:0] kb,
                             input logic [63:0] ha, input logic [63:0] hb,
                             input logic lk, input logic [63:0] nv);
        logic [s20_pkg::CFG_IDX_W-1:0] idx [7];
        logic [63:0]                   val [7];
        idx = '{s20_pkg::REG_KEY_LO_A, s20_pkg::REG_KEY_LO_B, s20_pkg::REG_KEY_HI_A,
                s20_pkg::REG_KEY_HI_B, s20_pkg::REG_LONG_KEY, s20_pkg::REG_NONCE,
                REG_UNUSED};
        val = '{ka, kb, ha, hb, {63'd0, lk}, nv, {$urandom, $urandom}};
        for (int i = 0; i < 7; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // a run of messages; most end on a final byte, any may be left open
    task automatic message_run(input int n_bytes, input bit hold_midway);
        int left;
        int len;
        left = n_bytes;
        while (left > 0)
        begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 140)
                                              : $urandom_range(1, 70);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
            begin
                if (hold_midway && left == n_bytes / 2)
                    hold_req = 1'b1;
                send_byte(8'($urandom_range(0, 255)),
                          (i == len - 1) && ($urandom_range(0, 7) != 0));
                left--;
            end
        end
    endtask

    initial
    begin
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, field extremes, final byte mid-block
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7e, 1'b1);
        drain();

        // short key, key and nonce registers at all ones
        load_regs('1, '1, '1, '1, 1'b0, '1);
        for (int i = 0; i < 10; i++)
            send_byte(i[0] ? 8'hff : 8'h00, i == 9);
        drain();

        // long key, extremes mixed
        load_regs('1, '0, '1, '0, 1'b1, 64'h8000_0000_0000_0001);
        message_run(120, 1'b1);
        drain();

        // random phases; registers rewritten while mid-block sometimes
        for (int p = 0; p < 5; p++)
        begin
            load_regs(rand64(), rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)),
                      rand64());
            message_run(140, 1'b0);
            drain();
        end

        // tail without idling on either side
        gaps_on = 1'b0;
        load_regs(rand64(), rand64(), rand64(), rand64(), 1'b1, rand64());
        message_run(100, 1'b0);
        drain();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: files.f
sv/s20_pkg.sv
sv/s20_stream_if.sv
sv/s20_ram.sv
sv/s20_core.sv
sv/salsa20_stream_cipher.sv
tb/salsa20_keystream_checker.sv
tb/salsa20_stream_cipher_tb.sv
